// ----- hw/rtl/battery_level_averager_macros.svh -----
// assertion helpers for the battery level averager
`ifndef BATTERY_LEVEL_AVERAGER_MACROS_SVH
`define BATTERY_LEVEL_AVERAGER_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define BLA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BLA_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define BLA_CHECK(lbl, prop, msg)
`define BLA_CHECK_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hw/rtl/bla_pkg.sv -----
package bla_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 13;
    localparam int PCT_W      = 7;
    localparam int FILLED_W   = 4;

    localparam int ADC_REF_MV = 3300;
    localparam int MV_SCALE_W = 13;
    localparam logic [MV_SCALE_W-1:0] MV_SCALE = MV_SCALE_W'(ADC_REF_MV * 2);
    localparam int MV_SHIFT   = 12;
    localparam int MV_PROD_W  = SAMPLE_W + MV_SCALE_W;
    localparam logic [MV_PROD_W-1:0] MV_ROUND = MV_PROD_W'((1 << MV_SHIFT) / 2);

    localparam int LUT_POINTS = 10;
    localparam int SEG_W      = 4;
    localparam logic [MV_W-1:0] LUT_MV [LUT_POINTS] = '{
        13'd3000, 13'd3200, 13'd3450, 13'd3600, 13'd3700,
        13'd3800, 13'd3900, 13'd4000, 13'd4100, 13'd4200
    };
    localparam logic [PCT_W-1:0] LUT_PCT [LUT_POINTS] = '{
        7'd0, 7'd5, 7'd15, 7'd35, 7'd50, 7'd65, 7'd75, 7'd85, 7'd95, 7'd100
    };

    localparam int PCT_NUM_W  = 13;
    localparam int PCT_DEN_W  = 8;

    typedef struct packed {
        logic                 clamp;
        logic [PCT_W-1:0]     base;
        logic [PCT_NUM_W-1:0] num;
        logic [PCT_DEN_W-1:0] den;
    } t_pct_job;

endpackage

// ----- hw/rtl/battery_level_averager.sv -----
// Battery level averager. Each 12-bit converter sample is written into a ring
// memory of WINDOW entries; a running sum and a fill count saturating at
// WINDOW are kept beside it, and every transaction yields one result: the
// truncated mean of the samples held, that mean in battery millivolts
// ((mean*6600+2048)/4096) and a charge percentage interpolated from a
// ten-point voltage table, clamped to 0 and 100. One sample is in work at a
// time. The mean and then the table interpolation are formed by the one
// bit-serial divider, in N steps, N being max(12+clog2(WINDOW),13); the
// interpolation division is skipped when the voltage lies outside the table.
// The result sits in an output register, so the next sample is taken while
// it waits, in the same cycle as the result is offered; a finished result
// stalls in its last state while the output register still holds an unread
// one. The ring needs no clearing pass after reset.
module battery_level_averager
    import bla_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_raw_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_avg_raw,
    output logic [MV_W-1:0]     o_battery_mv,
    output logic [PCT_W-1:0]    o_charge_percent,
    output logic [FILLED_W-1:0] o_filled
);

`include "battery_level_averager_macros.svh"

    localparam int WP_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int DIV_NUM_W = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
    localparam int DIV_DEN_W = (FILL_W > PCT_DEN_W) ? FILL_W : PCT_DEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_AVG,
        S_SCALE,
        S_LOOKUP,
        S_DIV_PCT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [WP_W-1:0]     r_wr_pos;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_avg;
    logic [MV_W-1:0]     r_mv;
    logic [PCT_W-1:0]    r_base;
    logic [PCT_W-1:0]    r_pct;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic [MV_W-1:0]     r_out_mv;
    logic [PCT_W-1:0]    r_out_pct;
    logic [FILLED_W-1:0] r_out_filled;

    logic [SAMPLE_W-1:0]  ring_rd_data;
    logic                 in_take;
    logic                 full;
    logic [SAMPLE_W-1:0]  old_sample;
    logic [SUM_W-1:0]     n_sum;
    logic [FILL_W-1:0]    n_fill;
    logic [WP_W-1:0]      n_wr_pos;
    logic [MV_PROD_W-1:0] mv_prod;
    logic [MV_W-1:0]      n_mv;
    t_pct_job             pct_job;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 div_wait;

    assign o_ready  = (r_state == S_IDLE);
    assign in_take  = i_valid && o_ready;
    assign div_wait = (r_state == S_DIV_AVG) || (r_state == S_DIV_PCT);

    bla_ring #(
        .DEPTH  (WINDOW),
        .ADDR_W (WP_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (in_take),
        .i_rd_addr (r_wr_pos),
        .o_rd_data (ring_rd_data),
        .i_wr_en   (r_state == S_UPDATE),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (r_sample)
    );

    // an entry not yet written is never used: below full the old sample counts as zero
    always_comb begin
        full       = (r_fill == FILL_W'(WINDOW));
        old_sample = full ? ring_rd_data : '0;
        n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
        n_fill     = full ? r_fill : r_fill + 1'b1;
        n_wr_pos   = (r_wr_pos == WP_W'(WINDOW - 1)) ? '0 : r_wr_pos + 1'b1;
        mv_prod    = MV_PROD_W'(r_avg) * MV_PROD_W'(MV_SCALE);
        n_mv       = MV_W'((mv_prod + MV_ROUND) >> MV_SHIFT);
    end

    bla_pct u_pct (
        .i_mv  (r_mv),
        .o_job (pct_job)
    );

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_NUM_W'(pct_job.num);
        div_divisor  = DIV_DEN_W'(pct_job.den);
        if (r_state == S_UPDATE) begin
            div_start    = 1'b1;
            div_dividend = DIV_NUM_W'(n_sum);
            div_divisor  = DIV_DEN_W'(n_fill);
        end else if (r_state == S_LOOKUP) begin
            div_start = !pct_job.clamp;
        end
    end

    bla_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_raw_sample;
                        r_state  <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_sum    <= n_sum;
                    r_fill   <= n_fill;
                    r_wr_pos <= n_wr_pos;
                    r_state  <= S_DIV_AVG;
                end
                S_DIV_AVG: begin
                    if (div_done) begin
                        r_avg   <= div_quo[SAMPLE_W-1:0];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_mv    <= n_mv;
                    r_state <= S_LOOKUP;
                end
                S_LOOKUP: begin
                    if (pct_job.clamp) begin
                        r_pct   <= pct_job.base;
                        r_state <= S_DONE;
                    end else begin
                        r_base  <= pct_job.base;
                        r_state <= S_DIV_PCT;
                    end
                end
                S_DIV_PCT: begin
                    if (div_done) begin
                        r_pct   <= r_base + div_quo[PCT_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_avg    <= r_avg;
                        r_out_mv     <= r_mv;
                        r_out_pct    <= r_pct;
                        r_out_filled <= FILLED_W'(r_fill);
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_avg_raw        = r_out_avg;
    assign o_battery_mv     = r_out_mv;
    assign o_charge_percent = r_out_pct;
    assign o_filled         = r_out_filled;

    `BLA_CHECK(a_fill_bound, r_fill <= FILL_W'(WINDOW), "fill count above window")
    `BLA_CHECK(a_empty_sum, (r_fill == '0) |-> (r_sum == '0), "sum nonzero with empty ring")
    `BLA_CHECK(a_take_update, in_take |=> (r_state == S_UPDATE), "accepted sample not updated")
    `BLA_CHECK(a_div_done_state, div_done |-> div_wait, "divider finished outside a wait state")
    `BLA_CHECK(a_pct_bound, o_valid |-> (o_charge_percent <= PCT_W'(100)), "charge above full scale")
    `BLA_CHECK_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_valid), "not idle after reset")

endmodule

// ----- hw/rtl/bla_ring.sv -----
module bla_ring
    import bla_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output logic [SAMPLE_W-1:0] o_rd_data,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [SAMPLE_W-1:0] i_wr_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/bla_div.sv -----
module bla_div
    import bla_pkg::*;
#(
    parameter int NUM_W = 15,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   n_shift;
    logic             n_fit;
    logic [DEN_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_quo[NUM_W-1]};
        n_fit   = (n_shift >= {1'b0, r_den});
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_fit ? n_diff[DEN_W-1:0] : n_shift[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], n_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/bla_pct.sv -----
module bla_pct
    import bla_pkg::*;
(
    input  logic [MV_W-1:0] i_mv,
    output t_pct_job        o_job
);

    localparam int PROD_W = MV_W + PCT_W;

    logic [SEG_W-1:0]  seg;
    logic [SEG_W-1:0]  seg_lo;
    logic [MV_W-1:0]   span;
    logic [MV_W-1:0]   off;
    logic [PCT_W-1:0]  rise;
    logic [PROD_W-1:0] prod;
    logic              below;
    logic              above;

    always_comb begin
        seg = SEG_W'(LUT_POINTS - 1);
        for (int k = LUT_POINTS - 1; k >= 1; k--) begin
            if (i_mv <= LUT_MV[k]) begin
                seg = SEG_W'(k);
            end
        end
        seg_lo = seg - 1'b1;
        span   = LUT_MV[seg] - LUT_MV[seg_lo];
        off    = i_mv - LUT_MV[seg_lo];
        rise   = LUT_PCT[seg] - LUT_PCT[seg_lo];
        prod   = PROD_W'(off) * PROD_W'(rise);
        below  = (i_mv <= LUT_MV[0]);
        above  = (i_mv >= LUT_MV[LUT_POINTS-1]);

        o_job.clamp = below || above;
        priority if (below) begin
            o_job.base = LUT_PCT[0];
        end else if (above) begin
            o_job.base = LUT_PCT[LUT_POINTS-1];
        end else begin
            o_job.base = LUT_PCT[seg_lo];
        end
        o_job.num = PCT_NUM_W'(prod + PROD_W'(span >> 1));
        o_job.den = PCT_DEN_W'(span);
    end

endmodule
